FILE: rtl/core/ihq_pkg.sv
// Shared constants, codes and types of the indexed min-heap queue.
package ihq_pkg;

    localparam int CAPACITY = 64;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = SLOT_W + 1;
    localparam int ID_W     = 6;
    localparam int NUM_IDS  = 2 ** ID_W;
    localparam int KEY_W    = 32;
    localparam int REQ_W    = 3;
    localparam int STAT_W   = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD  = 3'd0,
        REQ_BUILD = 3'd1,
        REQ_DEC   = 3'd2,
        REQ_INC   = 3'd3,
        REQ_POP   = 3'd4,
        REQ_CLEAR = 3'd5
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE    = 2'd0,
        STAT_IGNORED = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_REJECT  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CHK2,
        ST_BLD_RD,
        ST_BLD_LD,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_CMP,
        ST_POP_TOP,
        ST_POP_SET
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [KEY_W-1:0] key;
    } slot_t;

endpackage

FILE: rtl/core/indexed_min_heap_queue_core.sv
// Indexed min-heap queue: sequencer, slot and id memories, one shared key comparator.
// One request at a time: a start transfer is taken when busy is low, and the result
// comes back as a one-cycle done strobe that the receiver cannot hold off; the next
// start may be given in the cycle done is high. Load, clear, unknown requests, a pop
// on empty and an absent id finish in the check state; a decrease or increase that
// does not improve the key finishes once its current key is back. Decrease sifts the
// entry up a level at a time, increase sifts it down, and pop moves the last entry
// into the root and sifts it down. Build sifts each slot from 1 to count-1 up in turn.
// The pace is set by the single read port of the slot memory (keys and ids of the
// heap) and the one signed comparator that every compare step goes through. Heap
// depth is log2 of the capacity, so a single sift takes at most 6 levels here.
// No clearing pass: the id map carries one valid bit per id that reset and clear
// wipe at once; slot storage at or above the live count is never used.
module indexed_min_heap_queue_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ihq_pkg::REQ_W-1:0]           req_type,
    input  logic [ihq_pkg::ID_W-1:0]            entry_id,
    input  logic signed [ihq_pkg::KEY_W-1:0]    key_value,
    output logic                                done,
    output logic [ihq_pkg::ID_W-1:0]            out_id,
    output logic signed [ihq_pkg::KEY_W-1:0]    out_key,
    output logic [ihq_pkg::STAT_W-1:0]          status,
    output logic [ihq_pkg::CNT_W-1:0]           live_count
);
    import ihq_pkg::*;

    // slot memory holds {id, key} per heap slot; id memory holds the slot of each id
    slot_t             slot_mem [CAPACITY];
    logic [SLOT_W-1:0] id_mem   [NUM_IDS];

    state_t               state_reg, state_next;
    logic [REQ_W-1:0]     req_reg;
    logic [ID_W-1:0]      id_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [NUM_IDS-1:0]   valid_reg, valid_next;
    logic [SLOT_W-1:0]    s_reg, s_next;        // hole position of the sift
    logic [SLOT_W-1:0]    i_reg, i_next;        // build sweep index
    slot_t                x_reg, x_next;        // entry being sifted
    slot_t                best_reg, best_next;  // smaller of left child and x
    logic                 best_left_reg, best_left_next;
    slot_t                pop_reg, pop_next;    // popped minimum
    slot_t                slot_rd_reg;
    logic [SLOT_W-1:0]    id_rd_reg;

    logic                 done_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic signed [KEY_W-1:0] out_key_reg;
    logic [STAT_W-1:0]    status_reg;
    logic [CNT_W-1:0]     live_count_reg;

    // memory ports
    logic                 slot_we;
    logic [SLOT_W-1:0]    slot_wa, slot_ra;
    slot_t                slot_wd;
    logic                 id_we;
    logic [ID_W-1:0]      id_wa;
    logic [SLOT_W-1:0]    id_wd;

    // shared comparator
    logic signed [KEY_W-1:0] cmp_a, cmp_b;
    logic                 cmp_lt;

    // sequencer side outputs
    logic                 finish;
    status_t              fin_status;
    logic                 fin_sift;

    // index arithmetic
    logic                 accept;
    logic [SLOT_W-1:0]    s_dec;
    logic [SLOT_W-1:0]    parent;
    logic [CNT_W-1:0]     left_pos;
    logic [CNT_W:0]       right_pos;
    logic                 left_ok, right_ok;
    logic [CNT_W-1:0]     count_dec;
    logic [CNT_W-1:0]     i_inc;
    logic                 live;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);

    assign s_dec     = s_reg - 1'b1;
    assign parent    = s_dec >> 1;
    assign left_pos  = {s_reg, 1'b1};                         // 2s+1
    assign right_pos = (CNT_W+1)'(left_pos) + (CNT_W+1)'(1);  // 2s+2
    assign left_ok   = left_pos < count_reg;
    assign right_ok  = right_pos < {1'b0, count_reg};
    assign count_dec = count_reg - 1'b1;
    assign i_inc     = {1'b0, i_reg} + 1'b1;

    // an id is live when its valid bit is set and its slot is below the live count
    assign live      = valid_reg[id_reg] && ({1'b0, id_rd_reg} < count_reg);

    assign cmp_lt    = cmp_a < cmp_b;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
            done_reg  <= finish;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            id_reg  <= entry_id;
            key_reg <= key_value;
        end
        s_reg         <= s_next;
        i_reg         <= i_next;
        x_reg         <= x_next;
        best_reg      <= best_next;
        best_left_reg <= best_left_next;
        pop_reg       <= pop_next;
        if (finish)
        begin
            status_reg     <= fin_status;
            live_count_reg <= count_next;
            if ((req_reg == REQ_POP) && (fin_status == STAT_DONE))
            begin
                out_id_reg  <= pop_reg.id;
                out_key_reg <= pop_reg.key;
            end
            else
            begin
                out_id_reg  <= '0;
                out_key_reg <= '0;
            end
        end
    end

    // memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_wa] <= slot_wd;
        slot_rd_reg <= slot_mem[slot_ra];
    end

    always_ff @(posedge clk)
    begin
        if (id_we)
            id_mem[id_wa] <= id_wd;
        if (accept)
            id_rd_reg <= id_mem[entry_id];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        valid_next     = valid_reg;
        s_next         = s_reg;
        i_next         = i_reg;
        x_next         = x_reg;
        best_next      = best_reg;
        best_left_next = best_left_reg;
        pop_next       = pop_reg;
        slot_we        = 1'b0;
        slot_wa        = s_reg;
        slot_wd        = x_reg;
        slot_ra        = '0;
        id_we          = 1'b0;
        id_wa          = x_reg.id;
        id_wd          = s_reg;
        cmp_a          = x_reg.key;
        cmp_b          = slot_rd_reg.key;
        finish         = 1'b0;
        fin_status     = STAT_DONE;
        fin_sift       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_CHECK;
            end

            // id map lookup is back; decide the request
            ST_CHECK:
            begin
                unique case (req_reg)
                    REQ_LOAD:
                    begin
                        if ((CNT_W'(id_reg) != count_reg) ||
                            (count_reg >= CNT_W'(CAPACITY)) || live)
                        begin
                            finish     = 1'b1;
                            fin_status = STAT_REJECT;
                        end
                        else
                        begin
                            slot_we            = 1'b1;
                            slot_wa            = count_reg[SLOT_W-1:0];
                            slot_wd.id         = id_reg;
                            slot_wd.key        = key_reg;
                            id_we              = 1'b1;
                            id_wa              = id_reg;
                            id_wd              = count_reg[SLOT_W-1:0];
                            valid_next[id_reg] = 1'b1;
                            count_next         = count_reg + 1'b1;
                            finish             = 1'b1;
                        end
                    end
                    REQ_BUILD:
                    begin
                        if (count_reg > CNT_W'(1))
                        begin
                            i_next     = SLOT_W'(1);
                            state_next = ST_BLD_RD;
                        end
                        else
                            finish = 1'b1;
                    end
                    REQ_DEC, REQ_INC:
                    begin
                        if (!live)
                        begin
                            finish     = 1'b1;
                            fin_status = STAT_IGNORED;
                        end
                        else
                        begin
                            slot_ra    = id_rd_reg;
                            s_next     = id_rd_reg;
                            state_next = ST_CHK2;
                        end
                    end
                    REQ_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            finish     = 1'b1;
                            fin_status = STAT_EMPTY;
                        end
                        else
                        begin
                            slot_ra    = '0;
                            state_next = ST_POP_TOP;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        valid_next = '0;
                        count_next = '0;
                        finish     = 1'b1;
                    end
                    default:
                    begin
                        finish     = 1'b1;
                        fin_status = STAT_IGNORED;
                    end
                endcase
            end

            // current key is back: decrease needs new < old, increase new > old
            ST_CHK2:
            begin
                if (req_reg == REQ_DEC)
                begin
                    cmp_a = key_reg;
                    cmp_b = slot_rd_reg.key;
                end
                else
                begin
                    cmp_a = slot_rd_reg.key;
                    cmp_b = key_reg;
                end
                if (cmp_lt)
                begin
                    x_next.id  = slot_rd_reg.id;
                    x_next.key = key_reg;
                    state_next = (req_reg == REQ_DEC) ? ST_UP_RD : ST_DN_RDL;
                end
                else
                begin
                    finish     = 1'b1;
                    fin_status = STAT_IGNORED;
                end
            end

            ST_BLD_RD:
            begin
                slot_ra    = i_reg;
                state_next = ST_BLD_LD;
            end

            ST_BLD_LD:
            begin
                x_next     = slot_rd_reg;
                s_next     = i_reg;
                state_next = ST_UP_RD;
            end

            ST_UP_RD:
            begin
                if (s_reg == '0)
                    fin_sift = 1'b1;
                else
                begin
                    slot_ra    = parent;
                    state_next = ST_UP_CMP;
                end
            end

            // parent moves down into the hole only when strictly greater
            ST_UP_CMP:
            begin
                cmp_a = x_reg.key;
                cmp_b = slot_rd_reg.key;
                if (cmp_lt)
                begin
                    slot_we    = 1'b1;
                    slot_wd    = slot_rd_reg;
                    id_we      = 1'b1;
                    id_wa      = slot_rd_reg.id;
                    s_next     = parent;
                    state_next = ST_UP_RD;
                end
                else
                    fin_sift = 1'b1;
            end

            ST_DN_RDL:
            begin
                if (!left_ok)
                    fin_sift = 1'b1;
                else
                begin
                    slot_ra    = left_pos[SLOT_W-1:0];
                    state_next = ST_DN_RDR;
                end
            end

            // left child is back; keep the smaller of it and x
            ST_DN_RDR:
            begin
                cmp_a = slot_rd_reg.key;
                cmp_b = x_reg.key;
                if (cmp_lt)
                begin
                    best_next      = slot_rd_reg;
                    best_left_next = 1'b1;
                end
                else
                begin
                    best_next      = x_reg;
                    best_left_next = 1'b0;
                end
                slot_ra    = right_pos[SLOT_W-1:0];
                state_next = ST_DN_CMP;
            end

            // right child wins only when strictly smaller, so left wins ties
            ST_DN_CMP:
            begin
                cmp_a = slot_rd_reg.key;
                cmp_b = best_reg.key;
                if (right_ok && cmp_lt)
                begin
                    slot_we    = 1'b1;
                    slot_wd    = slot_rd_reg;
                    id_we      = 1'b1;
                    id_wa      = slot_rd_reg.id;
                    s_next     = right_pos[SLOT_W-1:0];
                    state_next = ST_DN_RDL;
                end
                else if (best_left_reg)
                begin
                    slot_we    = 1'b1;
                    slot_wd    = best_reg;
                    id_we      = 1'b1;
                    id_wa      = best_reg.id;
                    s_next     = left_pos[SLOT_W-1:0];
                    state_next = ST_DN_RDL;
                end
                else
                    fin_sift = 1'b1;
            end

            ST_POP_TOP:
            begin
                pop_next   = slot_rd_reg;
                slot_ra    = count_dec[SLOT_W-1:0];
                state_next = ST_POP_SET;
            end

            // last entry fills the root hole and sifts down
            ST_POP_SET:
            begin
                x_next                  = slot_rd_reg;
                valid_next[pop_reg.id]  = 1'b0;
                count_next              = count_dec;
                s_next                  = '0;
                state_next              = ST_DN_RDL;
            end

            default:
                state_next = ST_IDLE;
        endcase

        // sift ends: x lands in the hole; build moves on to the next slot
        if (fin_sift)
        begin
            slot_we = 1'b1;
            slot_wa = s_reg;
            slot_wd = x_reg;
            id_we   = 1'b1;
            id_wa   = x_reg.id;
            id_wd   = s_reg;
            if ((req_reg == REQ_BUILD) && (i_inc < count_reg))
            begin
                i_next     = i_inc[SLOT_W-1:0];
                state_next = ST_BLD_RD;
            end
            else
                finish = 1'b1;
        end

        if (finish)
            state_next = ST_IDLE;
    end

    assign done       = done_reg;
    assign out_id     = out_id_reg;
    assign out_key    = out_key_reg;
    assign status     = status_reg;
    assign live_count = live_count_reg;

endmodule

FILE: rtl/core/ihq_checker.sv
// Port-level checks of the indexed min-heap queue, bound to the top level.
module ihq_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                done,
    input logic [ihq_pkg::ID_W-1:0]            out_id,
    input logic signed [ihq_pkg::KEY_W-1:0]    out_key,
    input logic [ihq_pkg::STAT_W-1:0]          status,
    input logic [ihq_pkg::CNT_W-1:0]           live_count
);
    import ihq_pkg::*;

    // a taken start is followed by busy in the next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("start transfer not followed by busy");

    // a result only follows work and leaves the block free
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("done without preceding busy cycle");

    // a result whose status is not done carries a zero id and key
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STAT_DONE)) |-> ((out_id == '0) && (out_key == '0)))
        else $error("nonzero id or key on a result that is not a pop");

    // pop on empty reports an empty heap
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STAT_EMPTY)) |-> (live_count == '0))
        else $error("pop on empty with nonzero live count");

endmodule

bind indexed_min_heap_queue_core ihq_checker u_ihq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .out_id     (out_id),
    .out_key    (out_key),
    .status     (status),
    .live_count (live_count)
);
